// File: hdl/block_file_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// block file stream parser assertion macros
// concurrent assertion forms used by bfsp_decode
// ----------------------------------------------------------------------------
`ifndef BLOCK_FILE_STREAM_PARSER_DEFINES_SVH
`define BLOCK_FILE_STREAM_PARSER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define BFSP_ASSERT_NOW(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define BFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// widths, field kinds, parse phases and the result type of the parser
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int DATA_W  = 8;
    localparam int KIND_W  = 5;
    localparam int VALUE_W = 64;
    localparam int MAGIC_W = 32;
    localparam int BLEN_W  = 32;
    localparam int HASH_W  = 6;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET = 32'hD9B4BEF9;
    localparam logic [HASH_W-1:0]  HASH_BYTES  = 6'd32;
    localparam logic [DATA_W-1:0]  VAR_PREFIX  = 8'd253;

    localparam logic [KIND_W-1:0] KIND_START        = 5'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH       = 5'd1;
    localparam logic [KIND_W-1:0] KIND_BLKVER       = 5'd2;
    localparam logic [KIND_W-1:0] KIND_PREVHASH     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_MERKLE       = 5'd4;
    localparam logic [KIND_W-1:0] KIND_TIME         = 5'd5;
    localparam logic [KIND_W-1:0] KIND_BITS         = 5'd6;
    localparam logic [KIND_W-1:0] KIND_NONCE        = 5'd7;
    localparam logic [KIND_W-1:0] KIND_TXCOUNT      = 5'd8;
    localparam logic [KIND_W-1:0] KIND_TXVER        = 5'd9;
    localparam logic [KIND_W-1:0] KIND_INCOUNT      = 5'd10;
    localparam logic [KIND_W-1:0] KIND_INHASH       = 5'd11;
    localparam logic [KIND_W-1:0] KIND_INIDX        = 5'd12;
    localparam logic [KIND_W-1:0] KIND_INSCRIPTLEN  = 5'd13;
    localparam logic [KIND_W-1:0] KIND_INSCRIPT     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_SEQ          = 5'd15;
    localparam logic [KIND_W-1:0] KIND_OUTCOUNT     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_VALUE        = 5'd17;
    localparam logic [KIND_W-1:0] KIND_OUTSCRIPTLEN = 5'd18;
    localparam logic [KIND_W-1:0] KIND_OUTSCRIPT    = 5'd19;
    localparam logic [KIND_W-1:0] KIND_LOCKTIME     = 5'd20;
    localparam logic [KIND_W-1:0] KIND_END          = 5'd21;
    localparam logic [KIND_W-1:0] KIND_OVERRUN      = 5'd22;

    typedef enum logic [21:0] {
        PH_MAGIC     = 22'h000001,
        PH_LEN       = 22'h000002,
        PH_VER       = 22'h000004,
        PH_PREV      = 22'h000008,
        PH_MERKLE    = 22'h000010,
        PH_TIME      = 22'h000020,
        PH_BITS      = 22'h000040,
        PH_NONCE     = 22'h000080,
        PH_TXCOUNT   = 22'h000100,
        PH_TXVER     = 22'h000200,
        PH_INCOUNT   = 22'h000400,
        PH_INHASH    = 22'h000800,
        PH_INIDX     = 22'h001000,
        PH_INSLEN    = 22'h002000,
        PH_INSCRIPT  = 22'h004000,
        PH_SEQ       = 22'h008000,
        PH_OUTCOUNT  = 22'h010000,
        PH_VALUE     = 22'h020000,
        PH_OUTSLEN   = 22'h040000,
        PH_OUTSCRIPT = 22'h080000,
        PH_LOCK      = 22'h100000,
        PH_PAD       = 22'h200000
    } t_phase;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } t_result;

endpackage

// File: hdl/bfsp_stream_if.sv
// ----------------------------------------------------------------------------
// bfsp stream interfaces
// byte input channel and tagged field output channel, valid/ready
// ----------------------------------------------------------------------------
interface bfsp_byte_if import bfsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bfsp_field_if import bfsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  field_kind;
    logic [VALUE_W-1:0] field_value;

    modport source (output valid, output field_kind, output field_value, input ready);
    modport sink   (input valid, input field_kind, input field_value, output ready);
endinterface

// File: hdl/block_file_stream_parser.sv
// ----------------------------------------------------------------------------
// block_file_stream_parser
// byte-stream parser for serialized blocks, one tagged field per element
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, sustained, as long as the result
// sink keeps up; a byte's result (if it has one) passes from the input
// register through the decode step into the result register, where the
// sink can take it. The rate is set by the single decode step between
// those two registers: each byte does at most one shift-or into the field
// accumulator and at most two 64-bit count decrements. While the result
// register is full and not taken, the input register holds its byte, or
// takes one more if it is empty, then holds.
// The magic word register is to be written only while the parser is idle.
// ----------------------------------------------------------------------------
module block_file_stream_parser import bfsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [MAGIC_W-1:0] i_cfg_wr_data,
    bfsp_byte_if.sink          i_byte,
    bfsp_field_if.source       o_field
);

    // input register to decode stage
    logic              w_in_valid;
    logic [DATA_W-1:0] w_in_data;
    // decode fires when the result register can take its outcome
    logic              w_fire;
    logic              w_stall;
    t_result           w_res;

    // held byte moves on unless a finished result is still waiting
    assign w_fire = w_in_valid && !w_stall;

    bfsp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_fire),
        .o_valid   (w_in_valid),
        .o_data    (w_in_data)
    );

    // parse state, magic word register and the per-byte step
    bfsp_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_data        (w_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (w_res)
    );

    // bytes inside hashes and scripts come out one per transfer; other
    // fields come out once, on their last byte
    bfsp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .o_field (o_field),
        .o_stall (w_stall)
    );

endmodule

// File: hdl/bfsp_in_reg.sv
// ----------------------------------------------------------------------------
// bfsp_in_reg
// input register: holds one byte until the decode stage takes it
// ----------------------------------------------------------------------------
module bfsp_in_reg import bfsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bfsp_byte_if.sink         i_byte,
    input  logic              i_advance,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_data;
    logic              w_take;

    assign i_byte.ready = !r_valid || i_advance;
    assign w_take       = i_byte.valid && i_byte.ready;

    always_comb begin
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= i_byte.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hdl/bfsp_decode.sv
// ----------------------------------------------------------------------------
// bfsp_decode
// parse state and the per-byte step: magic search, fields, counts, padding
// ----------------------------------------------------------------------------
`include "block_file_stream_parser_defines.svh"

module bfsp_decode import bfsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [DATA_W-1:0]  i_data,
    input  logic               i_cfg_wr_en,
    input  logic [MAGIC_W-1:0] i_cfg_wr_data,
    output t_result            o_res
);

    typedef struct packed {
        logic [3:0]         bif;
        logic [1:0]         vw;
        logic [VALUE_W-1:0] acc;
    } t_field;

    logic [MAGIC_W-1:0] r_magic;
    t_phase             r_phase, n_phase;
    t_field             r_fld, n_fld;
    logic [BLEN_W-1:0]  r_blen, n_blen;
    logic [VALUE_W-1:0] r_tx, n_tx, r_in, n_in, r_out, n_out, r_scr, n_scr;
    logic [HASH_W-1:0]  r_hash, n_hash;

    logic [VALUE_W-1:0] w_b64;
    logic [3:0]         w_bif_inc, w_vidx, w_need;
    logic [VALUE_W-1:0] w_mag_acc, w_fix_acc, w_var_acc, w_var_val;
    logic               w_mag_full, w_mag_hit, w_fix4_done, w_fix8_done;
    logic               w_var_first, w_var_done;
    t_field             w_fld_mag, w_fld_fix4, w_fld_fix8, w_fld_var, w_fld_fresh;
    logic [VALUE_W-1:0] w_tx_dec, w_in_dec, w_out_dec, w_scr_dec;
    logic [HASH_W-1:0]  w_hash_dec;

    assign w_b64     = {{(VALUE_W-DATA_W){1'b0}}, i_data};
    assign w_bif_inc = r_fld.bif + 4'd1;
    assign w_vidx    = r_fld.bif - 4'd1;

    // magic words are aligned to the search start, low byte first
    assign w_mag_acc  = r_fld.acc | (w_b64 << {1'b0, r_fld.bif[1:0], 3'b000});
    assign w_mag_full = (w_bif_inc >= 4'd4);
    assign w_mag_hit  = w_mag_full && (w_mag_acc[MAGIC_W-1:0] == r_magic);
    assign w_fld_mag  = w_mag_full ? t_field'('0)
                                   : t_field'{bif: w_bif_inc, vw: r_fld.vw, acc: w_mag_acc};
    assign w_fld_fresh = '{bif: 4'd1, vw: 2'd0, acc: w_b64};

    // fixed little-endian fields
    assign w_fix_acc   = r_fld.acc | (w_b64 << {r_fld.bif[2:0], 3'b000});
    assign w_fix4_done = (w_bif_inc >= 4'd4);
    assign w_fix8_done = (w_bif_inc >= 4'd8);
    assign w_fld_fix4  = w_fix4_done ? t_field'('0)
                                     : t_field'{bif: w_bif_inc, vw: r_fld.vw, acc: w_fix_acc};
    assign w_fld_fix8  = w_fix8_done ? t_field'('0)
                                     : t_field'{bif: w_bif_inc, vw: r_fld.vw, acc: w_fix_acc};

    // variable-length counts: prefix byte then 2, 4 or 8 bytes
    assign w_var_first = (r_fld.bif == 4'd0);
    assign w_need      = 4'd1 << r_fld.vw;
    assign w_var_acc   = r_fld.acc | (w_b64 << {w_vidx[2:0], 3'b000});
    assign w_var_done  = w_var_first ? (i_data < VAR_PREFIX) : (r_fld.bif >= w_need);
    assign w_var_val   = w_var_first ? w_b64 : w_var_acc;
    always_comb begin
        if (w_var_done) begin
            w_fld_var = '0;
        end else if (w_var_first) begin
            w_fld_var = '{bif: 4'd1, vw: i_data[1:0], acc: '0};
        end else begin
            w_fld_var = '{bif: w_bif_inc, vw: r_fld.vw, acc: w_var_acc};
        end
    end

    // saturating count decrements
    assign w_tx_dec   = (r_tx   != '0) ? r_tx   - 64'd1 : r_tx;
    assign w_in_dec   = (r_in   != '0) ? r_in   - 64'd1 : r_in;
    assign w_out_dec  = (r_out  != '0) ? r_out  - 64'd1 : r_out;
    assign w_scr_dec  = (r_scr  != '0) ? r_scr  - 64'd1 : r_scr;
    assign w_hash_dec = (r_hash != '0) ? r_hash - 6'd1  : r_hash;

    always_comb begin
        n_phase = r_phase;
        n_fld   = r_fld;
        n_blen  = r_blen;
        n_tx    = r_tx;
        n_in    = r_in;
        n_out   = r_out;
        n_scr   = r_scr;
        n_hash  = r_hash;
        o_res   = '0;
        if (i_fire) begin
            case (r_phase)
                PH_MAGIC: begin
                    n_fld = w_fld_mag;
                    if (w_mag_hit) begin
                        n_phase = PH_LEN;
                        o_res   = '{valid: 1'b1, kind: KIND_START,
                                    value: {{(VALUE_W-MAGIC_W){1'b0}}, r_magic}};
                    end
                end
                PH_LEN: begin
                    n_fld = w_fld_fix4;
                    if (w_fix4_done) begin
                        n_blen  = w_fix_acc[BLEN_W-1:0];
                        n_phase = PH_VER;
                        o_res   = '{valid: 1'b1, kind: KIND_LENGTH, value: w_fix_acc};
                    end
                end
                PH_PAD: begin
                    if (r_blen == '0) begin
                        n_phase = PH_MAGIC;
                        n_fld   = w_fld_fresh;
                        o_res   = '{valid: 1'b1, kind: KIND_END, value: '0};
                    end else begin
                        n_blen = r_blen - 32'd1;
                    end
                end
                PH_VER, PH_PREV, PH_MERKLE, PH_TIME, PH_BITS, PH_NONCE, PH_TXCOUNT,
                PH_TXVER, PH_INCOUNT, PH_INHASH, PH_INIDX, PH_INSLEN, PH_INSCRIPT,
                PH_SEQ, PH_OUTCOUNT, PH_VALUE, PH_OUTSLEN, PH_OUTSCRIPT,
                PH_LOCK: begin
                    if (r_blen == '0) begin
                        n_phase = PH_MAGIC;
                        n_fld   = '0;
                        o_res   = '{valid: 1'b1, kind: KIND_OVERRUN, value: '0};
                    end else begin
                        n_blen = r_blen - 32'd1;
                        case (r_phase)
                            PH_VER: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_phase = PH_PREV;
                                    n_hash  = HASH_BYTES;
                                    o_res   = '{valid: 1'b1, kind: KIND_BLKVER,
                                                value: w_fix_acc};
                                end
                            end
                            PH_PREV: begin
                                n_hash = w_hash_dec;
                                o_res  = '{valid: 1'b1, kind: KIND_PREVHASH, value: w_b64};
                                if (w_hash_dec == '0) begin
                                    n_phase = PH_MERKLE;
                                    n_hash  = HASH_BYTES;
                                    n_fld   = '0;
                                end
                            end
                            PH_MERKLE: begin
                                n_hash = w_hash_dec;
                                o_res  = '{valid: 1'b1, kind: KIND_MERKLE, value: w_b64};
                                if (w_hash_dec == '0) begin
                                    n_phase = PH_TIME;
                                    n_fld   = '0;
                                end
                            end
                            PH_INHASH: begin
                                n_hash = w_hash_dec;
                                o_res  = '{valid: 1'b1, kind: KIND_INHASH, value: w_b64};
                                if (w_hash_dec == '0) begin
                                    n_phase = PH_INIDX;
                                    n_fld   = '0;
                                end
                            end
                            PH_TIME: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_phase = PH_BITS;
                                    o_res   = '{valid: 1'b1, kind: KIND_TIME, value: w_fix_acc};
                                end
                            end
                            PH_BITS: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_phase = PH_NONCE;
                                    o_res   = '{valid: 1'b1, kind: KIND_BITS, value: w_fix_acc};
                                end
                            end
                            PH_NONCE: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_phase = PH_TXCOUNT;
                                    o_res   = '{valid: 1'b1, kind: KIND_NONCE, value: w_fix_acc};
                                end
                            end
                            PH_TXCOUNT: begin
                                n_fld = w_fld_var;
                                if (w_var_done) begin
                                    n_tx    = w_var_val;
                                    n_phase = (w_var_val == '0) ? PH_PAD : PH_TXVER;
                                    o_res   = '{valid: 1'b1, kind: KIND_TXCOUNT,
                                                value: w_var_val};
                                end
                            end
                            PH_TXVER: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_phase = PH_INCOUNT;
                                    o_res   = '{valid: 1'b1, kind: KIND_TXVER, value: w_fix_acc};
                                end
                            end
                            PH_INCOUNT: begin
                                n_fld = w_fld_var;
                                if (w_var_done) begin
                                    n_in  = w_var_val;
                                    o_res = '{valid: 1'b1, kind: KIND_INCOUNT, value: w_var_val};
                                    if (w_var_val == '0) begin
                                        n_phase = PH_OUTCOUNT;
                                    end else begin
                                        n_phase = PH_INHASH;
                                        n_hash  = HASH_BYTES;
                                    end
                                end
                            end
                            PH_INIDX: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_phase = PH_INSLEN;
                                    o_res   = '{valid: 1'b1, kind: KIND_INIDX, value: w_fix_acc};
                                end
                            end
                            PH_INSLEN: begin
                                n_fld = w_fld_var;
                                if (w_var_done) begin
                                    n_scr   = w_var_val;
                                    n_phase = (w_var_val != '0) ? PH_INSCRIPT : PH_SEQ;
                                    o_res   = '{valid: 1'b1, kind: KIND_INSCRIPTLEN,
                                                value: w_var_val};
                                end
                            end
                            PH_INSCRIPT: begin
                                n_scr = w_scr_dec;
                                o_res = '{valid: 1'b1, kind: KIND_INSCRIPT, value: w_b64};
                                if (w_scr_dec == '0) begin
                                    n_phase = PH_SEQ;
                                    n_fld   = '0;
                                end
                            end
                            PH_SEQ: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_in  = w_in_dec;
                                    o_res = '{valid: 1'b1, kind: KIND_SEQ, value: w_fix_acc};
                                    if (w_in_dec != '0) begin
                                        n_phase = PH_INHASH;
                                        n_hash  = HASH_BYTES;
                                    end else begin
                                        n_phase = PH_OUTCOUNT;
                                    end
                                end
                            end
                            PH_OUTCOUNT: begin
                                n_fld = w_fld_var;
                                if (w_var_done) begin
                                    n_out   = w_var_val;
                                    n_phase = (w_var_val == '0) ? PH_LOCK : PH_VALUE;
                                    o_res   = '{valid: 1'b1, kind: KIND_OUTCOUNT,
                                                value: w_var_val};
                                end
                            end
                            PH_VALUE: begin
                                n_fld = w_fld_fix8;
                                if (w_fix8_done) begin
                                    n_phase = PH_OUTSLEN;
                                    o_res   = '{valid: 1'b1, kind: KIND_VALUE, value: w_fix_acc};
                                end
                            end
                            PH_OUTSLEN: begin
                                n_fld = w_fld_var;
                                if (w_var_done) begin
                                    n_scr = w_var_val;
                                    o_res = '{valid: 1'b1, kind: KIND_OUTSCRIPTLEN,
                                              value: w_var_val};
                                    if (w_var_val != '0) begin
                                        n_phase = PH_OUTSCRIPT;
                                    end else begin
                                        // empty script closes the output at once
                                        n_out   = w_out_dec;
                                        n_phase = (w_out_dec != '0) ? PH_VALUE : PH_LOCK;
                                    end
                                end
                            end
                            PH_OUTSCRIPT: begin
                                n_scr = w_scr_dec;
                                o_res = '{valid: 1'b1, kind: KIND_OUTSCRIPT, value: w_b64};
                                if (w_scr_dec == '0) begin
                                    n_out   = w_out_dec;
                                    n_phase = (w_out_dec != '0) ? PH_VALUE : PH_LOCK;
                                    n_fld   = '0;
                                end
                            end
                            PH_LOCK: begin
                                n_fld = w_fld_fix4;
                                if (w_fix4_done) begin
                                    n_tx    = w_tx_dec;
                                    n_phase = (w_tx_dec != '0) ? PH_TXVER : PH_PAD;
                                    o_res   = '{valid: 1'b1, kind: KIND_LOCKTIME,
                                                value: w_fix_acc};
                                end
                            end
                            default: begin
                                n_fld = r_fld;
                            end
                        endcase
                    end
                end
                default: begin
                    // corrupt phase: restart the search with this byte
                    n_phase = PH_MAGIC;
                    n_fld   = w_fld_fresh;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
        end else if (i_cfg_wr_en) begin
            r_magic <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_fld   <= '0;
            r_blen  <= '0;
            r_tx    <= '0;
            r_in    <= '0;
            r_out   <= '0;
            r_scr   <= '0;
            r_hash  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fld   <= n_fld;
            r_blen  <= n_blen;
            r_tx    <= n_tx;
            r_in    <= n_in;
            r_out   <= n_out;
            r_scr   <= n_scr;
            r_hash  <= n_hash;
        end
    end

    `BFSP_ASSERT_NEXT(a_overrun_restarts, i_clk, i_rst_n, i_fire && o_res.valid && (o_res.kind == KIND_OVERRUN), r_phase == PH_MAGIC, "overrun did not restart the magic search")
    `BFSP_ASSERT_NEXT(a_start_to_length, i_clk, i_rst_n, i_fire && o_res.valid && (o_res.kind == KIND_START), (r_phase == PH_LEN) && (r_fld.bif == 4'd0), "start not followed by a clean length field")
    `BFSP_ASSERT_NOW(a_hash_count_live, i_clk, i_rst_n, !((r_phase == PH_PREV) || (r_phase == PH_MERKLE) || (r_phase == PH_INHASH)) || (r_hash != '0), "hash phase with no bytes left")
    `BFSP_ASSERT_NOW(a_magic_word_span, i_clk, i_rst_n, (r_phase != PH_MAGIC) || (r_fld.bif < 4'd4), "magic search byte count past one word")

endmodule

// File: hdl/bfsp_out_reg.sv
// ----------------------------------------------------------------------------
// bfsp_out_reg
// result register: holds one tagged field until the sink takes it
// ----------------------------------------------------------------------------
module bfsp_out_reg import bfsp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_result      i_res,
    bfsp_field_if.source o_field,
    output logic         o_stall
);

    logic               r_valid;
    logic               n_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [VALUE_W-1:0] r_value;
    logic               w_load;

    assign w_load = i_load && i_res.valid;

    always_comb begin
        if (w_load) begin
            n_valid = 1'b1;
        end else if (o_field.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind  <= i_res.kind;
            r_value <= i_res.value;
        end
    end

    assign o_field.valid       = r_valid;
    assign o_field.field_kind  = r_kind;
    assign o_field.field_value = r_value;
    assign o_stall             = r_valid && !o_field.ready;

endmodule

// File: dv/block_file_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_file_stream_parser_tb
// self-checking bench: byte stream of framed blocks in, tagged fields out,
// each field compared against an in-bench parse of the same byte stream
// ----------------------------------------------------------------------------
module block_file_stream_parser_tb;
    import bfsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE       = 8;     // pipeline is two deep, plus margin
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned PHASE_BYTES  = 180;

    // parse phases, numbered so that each one equals the field kind it decodes
    typedef enum logic [4:0] {
        P_HUNT, P_LEN, P_VER, P_PREV, P_MERKLE, P_TIME, P_BITS, P_NONCE,
        P_TXCNT, P_TXVER, P_INCNT, P_INHASH, P_INIDX, P_INSLEN, P_INSCRIPT,
        P_SEQ, P_OUTCNT, P_VALUE, P_OUTSLEN, P_OUTSCRIPT, P_LOCK, P_PAD
    } t_parse_ph;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } t_field;

    typedef struct packed {
        logic [DATA_W-1:0] b;
        bit                typed;
        t_field            fld;
    } t_stim_row;

    // directed bytes; a field is typed in where it is plain from the stream
    localparam t_stim_row DIRECTED [27] = '{
        // default magic right after reset
        '{8'hF9, 1'b0, '0}, '{8'hBE, 1'b0, '0}, '{8'hB4, 1'b0, '0},
        '{8'hD9, 1'b1, '{KIND_START, 64'h0000_0000_D9B4_BEF9}},
        // declared length of one byte
        '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_LENGTH, 64'd1}},
        // one version byte uses up the length, the next one overruns
        '{8'h04, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_OVERRUN, 64'd0}},
        // magic one byte off the word grid must be missed
        '{8'h55, 1'b0, '0}, '{8'hF9, 1'b0, '0}, '{8'hBE, 1'b0, '0},
        '{8'hB4, 1'b0, '0}, '{8'hD9, 1'b0, '0}, '{8'h11, 1'b0, '0},
        '{8'h22, 1'b0, '0}, '{8'h33, 1'b0, '0},
        // aligned again, zero length, first header byte overruns
        '{8'hF9, 1'b0, '0}, '{8'hBE, 1'b0, '0}, '{8'hB4, 1'b0, '0},
        '{8'hD9, 1'b1, '{KIND_START, 64'h0000_0000_D9B4_BEF9}},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_LENGTH, 64'd0}},
        '{8'h7E, 1'b1, '{KIND_OVERRUN, 64'd0}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [MAGIC_W-1:0] i_cfg_wr_data;

    bfsp_byte_if  byte_ch ();
    bfsp_field_if field_ch ();

    block_file_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (byte_ch),
        .o_field       (field_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // parser state as the bench sees it
    // ------------------------------------------------------------------------
    logic [MAGIC_W-1:0] magic_cfg;
    t_parse_ph          ph;
    logic [3:0]         fcnt;        // bytes taken in the current field
    logic [63:0]        facc;        // little-endian field accumulator
    logic [1:0]         vwid;        // varint width code after a prefix byte
    logic [31:0]        len_left;
    logic [63:0]        tx_left;
    logic [63:0]        in_left;
    logic [63:0]        out_left;
    logic [63:0]        scr_left;
    logic [5:0]         hash_left;

    // queues fill at the front and drain from the back
    t_field      fields_due [$];
    logic [7:0]  plan_q [$];        // bytes waiting to be sent
    logic [7:0]  body_q [$];        // block body under construction, newest first
    int unsigned err_cnt = 0;
    int unsigned cyc_cnt = 0;
    int unsigned burst_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    function automatic void plan_add(logic [7:0] x);
        plan_q.push_front(x);
    endfunction

    function automatic void body_add(logic [7:0] x);
        body_q.push_front(x);
    endfunction

    function automatic void field_clear();
        fcnt = '0;
        facc = '0;
        vwid = '0;
    endfunction

    function automatic void goto_ph(t_parse_ph p);
        ph = p;
        field_clear();
    endfunction

    // one byte of the word-aligned magic hunt, high when the word matches
    function automatic bit hunt_byte(logic [7:0] b);
        facc |= 64'(b) << (8 * fcnt[1:0]);
        fcnt = fcnt + 4'd1;
        if (fcnt < 4) return 1'b0;
        if (facc[31:0] == magic_cfg) begin
            goto_ph(P_LEN);
            return 1'b1;
        end
        field_clear();
        return 1'b0;
    endfunction

    function automatic bit take_le(logic [7:0] b, int n, output logic [63:0] v);
        facc |= 64'(b) << (8 * fcnt[2:0]);
        fcnt = fcnt + 4'd1;
        if (int'(fcnt) < n) return 1'b0;
        v = facc;
        field_clear();
        return 1'b1;
    endfunction

    // variable-length count: below 253 is the value, 253/254/255 take 2/4/8 more
    function automatic bit take_varint(logic [7:0] b, output logic [63:0] v);
        int need;
        if (fcnt == 0) begin
            if (b < VAR_PREFIX) begin
                v = 64'(b);
                field_clear();
                return 1'b1;
            end
            vwid = 2'(b - 8'd252);
            fcnt = 4'd1;
            facc = '0;
            return 1'b0;
        end
        facc |= 64'(b) << (8 * 3'(fcnt - 4'd1));
        fcnt = fcnt + 4'd1;
        need = 1 << vwid;
        if (int'(fcnt) - 1 < need) return 1'b0;
        v = facc;
        field_clear();
        return 1'b1;
    endfunction

    // feeds one byte through the parse, returns high with the field it completes
    function automatic bit parse_byte(logic [7:0] b, output logic [KIND_W-1:0] kind,
                                      output logic [VALUE_W-1:0] val);
        t_parse_ph   cur;
        t_parse_ph   nxt;
        logic [63:0] v;
        cur  = ph;
        nxt  = ph;
        v    = '0;
        kind = KIND_START;
        val  = '0;
        if (cur == P_HUNT) begin
            if (!hunt_byte(b)) return 1'b0;
            val = 64'(magic_cfg);
            return 1'b1;
        end
        // length bytes are not counted against the length itself
        if (cur == P_LEN) begin
            if (!take_le(b, 4, v)) return 1'b0;
            len_left = v[31:0];
            ph = P_VER;
            kind = KIND_LENGTH;
            val = v;
            return 1'b1;
        end
        // padding is silent; the byte after it closes the block and starts the hunt
        if (cur == P_PAD) begin
            if (len_left == 0) begin
                goto_ph(P_HUNT);
                void'(hunt_byte(b));
                kind = KIND_END;
                return 1'b1;
            end
            len_left--;
            return 1'b0;
        end
        // parse ran past the declared length: this byte is dropped
        if (len_left == 0) begin
            goto_ph(P_HUNT);
            kind = KIND_OVERRUN;
            return 1'b1;
        end
        len_left--;
        case (cur)
            P_VER: begin
                if (!take_le(b, 4, v)) return 1'b0;
                nxt = P_PREV;
                hash_left = HASH_BYTES;
            end
            P_PREV, P_MERKLE, P_INHASH: begin
                v = 64'(b);
                if (hash_left != 0) hash_left--;
                if (hash_left == 0) begin
                    nxt = (cur == P_PREV) ? P_MERKLE : (cur == P_MERKLE) ? P_TIME : P_INIDX;
                    hash_left = (cur == P_PREV) ? HASH_BYTES : '0;
                end
            end
            P_TIME, P_BITS, P_NONCE: begin
                if (!take_le(b, 4, v)) return 1'b0;
                nxt = t_parse_ph'(cur + 1);
            end
            P_TXCNT: begin
                if (!take_varint(b, v)) return 1'b0;
                tx_left = v;
                nxt = (v == 0) ? P_PAD : P_TXVER;
            end
            P_TXVER: begin
                if (!take_le(b, 4, v)) return 1'b0;
                nxt = P_INCNT;
            end
            P_INCNT: begin
                if (!take_varint(b, v)) return 1'b0;
                in_left = v;
                if (v == 0) nxt = P_OUTCNT;
                else begin
                    nxt = P_INHASH;
                    hash_left = HASH_BYTES;
                end
            end
            P_INIDX: begin
                if (!take_le(b, 4, v)) return 1'b0;
                nxt = P_INSLEN;
            end
            P_INSLEN, P_OUTSLEN: begin
                if (!take_varint(b, v)) return 1'b0;
                scr_left = v;
                if (v != 0) nxt = t_parse_ph'(cur + 1);
                else if (cur == P_INSLEN) nxt = P_SEQ;
                else begin
                    if (out_left != 0) out_left--;
                    nxt = (out_left != 0) ? P_VALUE : P_LOCK;
                end
            end
            P_INSCRIPT, P_OUTSCRIPT: begin
                v = 64'(b);
                if (scr_left != 0) scr_left--;
                if (scr_left == 0) begin
                    if (cur == P_INSCRIPT) nxt = P_SEQ;
                    else begin
                        if (out_left != 0) out_left--;
                        nxt = (out_left != 0) ? P_VALUE : P_LOCK;
                    end
                end
            end
            P_SEQ: begin
                if (!take_le(b, 4, v)) return 1'b0;
                if (in_left != 0) in_left--;
                if (in_left != 0) begin
                    nxt = P_INHASH;
                    hash_left = HASH_BYTES;
                end else begin
                    nxt = P_OUTCNT;
                end
            end
            P_OUTCNT: begin
                if (!take_varint(b, v)) return 1'b0;
                out_left = v;
                nxt = (v == 0) ? P_LOCK : P_VALUE;
            end
            P_VALUE: begin
                if (!take_le(b, 8, v)) return 1'b0;
                nxt = P_OUTSLEN;
            end
            default: begin
                if (!take_le(b, 4, v)) return 1'b0;
                if (tx_left != 0) tx_left--;
                nxt = (tx_left != 0) ? P_TXVER : P_PAD;
            end
        endcase
        if (nxt != cur) goto_ph(nxt);
        kind = KIND_W'(cur);
        val = v;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // block stream generation
    // ------------------------------------------------------------------------
    // mostly random, now and then all zeros or all ones
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void put_le(logic [63:0] x, int n);
        for (int i = 0; i < n; i++) body_add(x[8*i +: 8]);
    endfunction

    // count in a random encoding wide enough to hold it, minimal or not
    function automatic void put_count(logic [63:0] c);
        int unsigned enc;
        enc = $urandom_range(0, 3);
        if (enc == 0 && c < 64'(VAR_PREFIX)) begin
            body_add(c[7:0]);
        end else if (enc <= 1 && c <= 64'hFFFF) begin
            body_add(8'd253);
            put_le(c, 2);
        end else if (enc <= 2 && c <= 64'hFFFF_FFFF) begin
            body_add(8'd254);
            put_le(c, 4);
        end else begin
            body_add(8'd255);
            put_le(c, 8);
        end
    endfunction

    function automatic void put_script();
        int unsigned slen;
        slen = $urandom_range(0, 3);
        put_count(64'(slen));
        repeat (slen) body_add(8'($urandom));
    endfunction

    // one framed block, optional noise ahead of it, appended to the send plan
    function automatic void gen_block(logic [31:0] m);
        int unsigned ntx, nin, nout, skew, pad, keep;
        bit          huge, trunc;
        logic [31:0] decl;
        body_q.delete();
        case ($urandom_range(0, 7))
            0, 1: repeat (4 * $urandom_range(1, 2)) plan_add(8'($urandom));
            2: begin
                // magic off the word grid, then fill back onto the grid
                skew = $urandom_range(1, 3);
                repeat (skew) plan_add(8'($urandom));
                for (int i = 0; i < 4; i++) plan_add(m[8*i +: 8]);
                repeat (4 - skew) plan_add(8'($urandom));
            end
            default: ;
        endcase

        put_le(rand_word(), 4);
        repeat (64) body_add(8'($urandom));
        repeat (3) put_le(rand_word(), 4);
        // huge transaction count: only the declared length can end the block
        huge = ($urandom_range(0, 5) == 0);
        ntx = huge ? 1 : $urandom_range(0, 2);
        put_count(huge ? {1'b1, 63'({$urandom, $urandom})} : 64'(ntx));
        repeat (ntx) begin
            put_le(rand_word(), 4);
            nin = $urandom_range(0, 2);
            put_count(64'(nin));
            repeat (nin) begin
                repeat (32) body_add(8'($urandom));
                put_le(rand_word(), 4);
                put_script();
                put_le(rand_word(), 4);
            end
            nout = $urandom_range(0, 2);
            put_count(64'(nout));
            repeat (nout) begin
                put_le(rand_word(), 8);
                put_script();
            end
            put_le(rand_word(), 4);
        end

        trunc = huge || ($urandom_range(0, 3) == 0);
        pad = 0;
        if (trunc) begin
            keep = $urandom_range(body_q.size() / 2, body_q.size() - (huge ? 0 : 1));
        end else begin
            keep = body_q.size();
            pad = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        end
        decl = 32'(keep + pad);

        for (int i = 0; i < 4; i++) plan_add(m[8*i +: 8]);
        for (int i = 0; i < 4; i++) plan_add(decl[8*i +: 8]);
        for (int i = 0; i < keep; i++) plan_add(body_q[body_q.size() - 1 - i]);
        // a short length leaves one byte to overrun; a long one leaves padding
        if (trunc) plan_add(8'($urandom));
        repeat (pad) plan_add(8'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // byte sender: bursts with gaps, one transfer per call
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, bit typed, t_field typed_fld);
        int unsigned        gap;
        logic [KIND_W-1:0]  k;
        logic [VALUE_W-1:0] v;
        t_field             f;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                gap = 0;
                burst_left = $urandom_range(60, 120);
            end else begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 12);
            end
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                byte_ch.data_byte <= 8'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        burst_left--;
        // the byte was taken at this edge
        if (parse_byte(b, k, v)) begin
            f.kind = k;
            f.value = v;
            fields_due.push_front(typed ? typed_fld : f);
        end
    endtask

    // stop sending, let every expected field come out and the pipe empty
    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (fields_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_magic(logic [31:0] m);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        magic_cfg = m;
    endtask

    // ------------------------------------------------------------------------
    // field receiver: ready pattern of its own, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned run;
        int unsigned mode;
        forever begin
            if (hold_req && !hold_done) begin
                // long stall so the parser backs up into its byte input
                hold_done = 1'b1;
                field_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 40);
                mode = $urandom_range(0, 2);
                repeat (run) begin
                    case (mode)
                        0:       field_ch.ready <= 1'b1;
                        1:       field_ch.ready <= 1'($urandom_range(0, 1));
                        default: field_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // field checker, oldest expectation first
    always @(posedge i_clk) begin
        t_field want;
        if (i_rst_n && field_ch.valid && field_ch.ready) begin
            if (fields_due.size() == 0) begin
                $error("field with nothing expected: kind %0d value %h",
                       field_ch.field_kind, field_ch.field_value);
                err_cnt++;
            end else begin
                want = fields_due.pop_back();
                if (field_ch.field_kind !== want.kind) begin
                    $error("field_kind mismatch: expected %0d, actual %0d",
                           want.kind, field_ch.field_kind);
                    err_cnt++;
                end
                if (field_ch.field_value !== want.value) begin
                    $error("field_value mismatch: expected %h, actual %h",
                           want.value, field_ch.field_value);
                    err_cnt++;
                end
            end
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] magic_set [4];
        int unsigned sent;

        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= '0;

        magic_cfg = MAGIC_RESET;
        goto_ph(P_HUNT);
        len_left  = '0;
        tx_left   = '0;
        in_left   = '0;
        out_left  = '0;
        scr_left  = '0;
        hash_left = '0;

        // all-zero and all-ones magic, a random one, then back to the default
        magic_set[0] = 32'h0000_0000;
        magic_set[1] = 32'hFFFF_FFFF;
        magic_set[2] = $urandom;
        magic_set[3] = MAGIC_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_byte(DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].fld);

        foreach (magic_set[p]) begin
            write_magic(magic_set[p]);
            if (p == 0) hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                gen_block(magic_cfg);
                sent += plan_q.size();
                while (plan_q.size() != 0) send_byte(plan_q.pop_back(), 1'b0, '0);
            end
        end

        drain();
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
